FILE: design/gac_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gac_pkg: shared types and constants for the gamepad activity classifier
// Item layouts, result kinds, register indexes, controller states and the
// command and status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package gac_pkg;

  localparam int AXIS_BITS        = 16;
  localparam int BUTTON_COUNT_DEF = 32;
  localparam int PULL_BITS        = 15;
  localparam int MUL_W            = 33;

  localparam logic [15:0] PRESS_MAG = 16'd32768;

  localparam logic [14:0] STICK_ENTER_RST   = 15'd8192;
  localparam logic [15:0] STICK_MOVE_RST    = 16'd3932;
  localparam logic [14:0] STICK_COS_RST     = 15'd32051;
  localparam logic [14:0] TRIGGER_ENTER_RST = 15'd4915;
  localparam logic [14:0] TRIGGER_MOVE_RST  = 15'd2621;
  localparam logic [31:0] TOUCH_MASK_RST    = 32'd0;

  typedef struct packed {
    logic [31:0]                  buttons;
    logic signed [AXIS_BITS-1:0]  left_x;
    logic signed [AXIS_BITS-1:0]  left_y;
    logic signed [AXIS_BITS-1:0]  right_x;
    logic signed [AXIS_BITS-1:0]  right_y;
    logic [PULL_BITS-1:0]         left_pull;
    logic [PULL_BITS-1:0]         right_pull;
    logic [63:0]                  sequence_req;
    logic [63:0]                  stamp_us;
  } in_item_t;

  typedef struct packed {
    logic [3:0]  kind;
    logic [4:0]  control;
    logic [15:0] magnitude;
    logic [31:0] down_mask;
    logic [63:0] seq_out;
    logic [63:0] stamp_out;
    logic        last;
  } out_item_t;

  typedef enum logic [3:0] {
    K_PRESS, K_TOUCH, K_RELEASE,
    K_LSTICK_ENTER, K_LSTICK_CHANGE, K_RSTICK_ENTER, K_RSTICK_CHANGE,
    K_LTRIG_ENTER, K_LTRIG_CHANGE, K_RTRIG_ENTER, K_RTRIG_CHANGE,
    K_FRAME_END
  } kind_t;

  typedef enum logic [2:0] {
    CFG_STICK_ENTER, CFG_STICK_MOVE, CFG_STICK_COS,
    CFG_TRIGGER_ENTER, CFG_TRIGGER_MOVE, CFG_TOUCH_MASK
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_BTN, ST_ENTER2, ST_SMUL, ST_SDEC, ST_TRG, ST_FEND
  } state_t;

  typedef enum logic [3:0] {
    OP_E2, OP_CXX, OP_CYY, OP_PXX, OP_PYY, OP_DOT0, OP_DOT1,
    OP_DD, OP_PC, OP_C2, OP_LO, OP_HI
  } mul_op_t;

  typedef enum logic [1:0] {
    SRC_BTN, SRC_STICK, SRC_TRG, SRC_FRAME
  } emit_src_t;

  typedef struct packed {
    logic      take;
    logic      btn_adv;
    logic      mul_go;
    mul_op_t   mul_op;
    logic      sqrt_go;
    logic      stick_sel;
    logic      trg_sel;
    logic      emit;
    emit_src_t src;
    logic      commit;
  } cmd_t;

  typedef struct packed {
    logic btn_edge;
    logic btn_last;
    logic sqrt_busy;
    logic stick_fire;
    logic trg_fire;
    logic out_free;
  } sts_t;

endpackage
`default_nettype wire

FILE: design/gac_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gac_ctrl: sequencer for one report
// Steps through button scan, stick arithmetic, trigger checks and frame end.
// ----------------------------------------------------------------------------
module gac_ctrl import gac_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic      in_ready,
  output cmd_t      cmd,
  input  wire sts_t sts
);

  state_t  state_r, state_nxt;
  mul_op_t op_r, op_nxt;
  logic    stick_r, stick_nxt;
  logic    trg_r, trg_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      op_r    <= OP_CXX;
      stick_r <= 1'b0;
      trg_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      op_r    <= op_nxt;
      stick_r <= stick_nxt;
      trg_r   <= trg_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    stick_nxt     = stick_r;
    trg_nxt       = trg_r;
    in_ready      = 1'b0;
    cmd           = '0;
    cmd.mul_op    = op_r;
    cmd.stick_sel = stick_r;
    cmd.trg_sel   = trg_r;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.take  = 1'b1;
          state_nxt = ST_BTN;
        end
      end
      ST_BTN: begin
        // hold on an edge while the output register is full
        if (!sts.btn_edge || sts.out_free) begin
          cmd.emit    = sts.btn_edge;
          cmd.src     = SRC_BTN;
          cmd.btn_adv = 1'b1;
          if (sts.btn_last) begin
            state_nxt = ST_ENTER2;
          end
        end
      end
      ST_ENTER2: begin
        cmd.mul_go = 1'b1;
        cmd.mul_op = OP_E2;
        stick_nxt  = 1'b0;
        op_nxt     = OP_CXX;
        state_nxt  = ST_SMUL;
      end
      ST_SMUL: begin
        cmd.mul_go = 1'b1;
        // current squared length is ready: start the root
        if (op_r == OP_PXX) begin
          cmd.sqrt_go = 1'b1;
        end
        if (op_r == OP_HI) begin
          state_nxt = ST_SDEC;
        end else begin
          op_nxt = mul_op_t'(op_r + 4'd1);
        end
      end
      ST_SDEC: begin
        if (!sts.sqrt_busy && (!sts.stick_fire || sts.out_free)) begin
          cmd.emit = sts.stick_fire;
          cmd.src  = SRC_STICK;
          if (!stick_r) begin
            stick_nxt = 1'b1;
            op_nxt    = OP_CXX;
            state_nxt = ST_SMUL;
          end else begin
            trg_nxt   = 1'b0;
            state_nxt = ST_TRG;
          end
        end
      end
      ST_TRG: begin
        if (!sts.trg_fire || sts.out_free) begin
          cmd.emit = sts.trg_fire;
          cmd.src  = SRC_TRG;
          if (!trg_r) begin
            trg_nxt = 1'b1;
          end else begin
            state_nxt = ST_FEND;
          end
        end
      end
      ST_FEND: begin
        if (sts.out_free) begin
          cmd.emit   = 1'b1;
          cmd.src    = SRC_FRAME;
          cmd.commit = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

FILE: design/gac_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gac_dp: datapath of the classifier
// Holds the report, prior state, registers, shared multiplier, root unit
// and the output register.
// ----------------------------------------------------------------------------
module gac_dp import gac_pkg::*; #(
  parameter int BUTTON_COUNT = BUTTON_COUNT_DEF
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  cfg_valid,
  output logic       cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [31:0] cfg_data,
  input  wire in_item_t    in_data,
  output logic       out_valid,
  input  wire logic  out_ready,
  output out_item_t  out_data,
  input  wire cmd_t  cmd,
  output sts_t       sts
);

  localparam int IDX_W = (BUTTON_COUNT > 1) ? $clog2(BUTTON_COUNT) : 1;

  function automatic logic signed [MUL_W-1:0] sext(input logic [AXIS_BITS-1:0] v);
    sext = {{(MUL_W-AXIS_BITS){v[AXIS_BITS-1]}}, v};
  endfunction

  in_item_t cur_r;
  logic [31:0] prior_btn_r;
  logic [AXIS_BITS-1:0] prior_lx_r, prior_ly_r, prior_rx_r, prior_ry_r;
  logic [PULL_BITS-1:0] prior_lp_r, prior_rp_r;

  logic [14:0] cfg_enter_r, cfg_cos_r, cfg_tenter_r, cfg_tmove_r;
  logic [15:0] cfg_move_r;
  logic [31:0] cfg_touch_r;

  logic [IDX_W-1:0] idx_r;

  logic signed [MUL_W-1:0] acc_r, dot_r;
  logic [31:0] cc_r, pp_r;
  logic [63:0] dd_r, pc_r;
  logic [29:0] c2_r, e2_r;
  logic [61:0] rlo_r;
  logic [93:0] rhs_r;

  logic [31:0] sq_x_r, sq_r, sq_bit_r;

  logic      out_valid_r;
  out_item_t out_r;

  assign cfg_ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_enter_r  <= STICK_ENTER_RST;
      cfg_move_r   <= STICK_MOVE_RST;
      cfg_cos_r    <= STICK_COS_RST;
      cfg_tenter_r <= TRIGGER_ENTER_RST;
      cfg_tmove_r  <= TRIGGER_MOVE_RST;
      cfg_touch_r  <= TOUCH_MASK_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_STICK_ENTER:   cfg_enter_r  <= cfg_data[14:0];
        CFG_STICK_MOVE:    cfg_move_r   <= cfg_data[15:0];
        CFG_STICK_COS:     cfg_cos_r    <= cfg_data[14:0];
        CFG_TRIGGER_ENTER: cfg_tenter_r <= cfg_data[14:0];
        CFG_TRIGGER_MOVE:  cfg_tmove_r  <= cfg_data[14:0];
        CFG_TOUCH_MASK:    cfg_touch_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  // report latch and prior state
  always_ff @(posedge clk) begin
    if (cmd.take) begin
      cur_r <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prior_btn_r <= '0;
      prior_lx_r  <= '0;
      prior_ly_r  <= '0;
      prior_rx_r  <= '0;
      prior_ry_r  <= '0;
      prior_lp_r  <= '0;
      prior_rp_r  <= '0;
    end else if (cmd.commit) begin
      prior_btn_r <= cur_r.buttons;
      prior_lx_r  <= cur_r.left_x;
      prior_ly_r  <= cur_r.left_y;
      prior_rx_r  <= cur_r.right_x;
      prior_ry_r  <= cur_r.right_y;
      prior_lp_r  <= cur_r.left_pull;
      prior_rp_r  <= cur_r.right_pull;
    end
  end

  // button scan
  logic cur_bit, prior_bit, touch_hit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= '0;
    end else if (cmd.take) begin
      idx_r <= '0;
    end else if (cmd.btn_adv) begin
      idx_r <= idx_r + 1'b1;
    end
  end

  assign cur_bit   = cur_r.buttons[idx_r];
  assign prior_bit = prior_btn_r[idx_r];
  assign touch_hit = (cfg_touch_r == (32'd1 << idx_r));

  // shared multiplier
  logic signed [MUL_W-1:0] cx, cy, px, py, ma, mb;
  logic signed [2*MUL_W-1:0] prod;

  assign cx = cmd.stick_sel ? sext(cur_r.right_x) : sext(cur_r.left_x);
  assign cy = cmd.stick_sel ? sext(cur_r.right_y) : sext(cur_r.left_y);
  assign px = cmd.stick_sel ? sext(prior_rx_r) : sext(prior_lx_r);
  assign py = cmd.stick_sel ? sext(prior_ry_r) : sext(prior_ly_r);

  always_comb begin
    ma = '0;
    mb = '0;
    case (cmd.mul_op)
      OP_E2:   begin ma = $signed({18'd0, cfg_enter_r}); mb = ma; end
      OP_CXX:  begin ma = cx; mb = cx; end
      OP_CYY:  begin ma = cy; mb = cy; end
      OP_PXX:  begin ma = px; mb = px; end
      OP_PYY:  begin ma = py; mb = py; end
      OP_DOT0: begin ma = px; mb = cx; end
      OP_DOT1: begin ma = py; mb = cy; end
      OP_DD:   begin ma = dot_r; mb = dot_r; end
      OP_PC:   begin ma = $signed({1'b0, pp_r}); mb = $signed({1'b0, cc_r}); end
      OP_C2:   begin ma = $signed({18'd0, cfg_cos_r}); mb = ma; end
      OP_LO:   begin ma = $signed({1'b0, pc_r[31:0]}); mb = $signed({3'd0, c2_r}); end
      OP_HI:   begin ma = $signed({1'b0, pc_r[63:32]}); mb = $signed({3'd0, c2_r}); end
      default: ;
    endcase
  end

  assign prod = ma * mb;

  always_ff @(posedge clk) begin
    if (cmd.mul_go) begin
      case (cmd.mul_op)
        OP_E2:   e2_r  <= prod[29:0];
        OP_CXX:  acc_r <= $signed(prod[MUL_W-1:0]);
        OP_CYY:  cc_r  <= 32'(acc_r + $signed(prod[MUL_W-1:0]));
        OP_PXX:  acc_r <= $signed(prod[MUL_W-1:0]);
        OP_PYY:  pp_r  <= 32'(acc_r + $signed(prod[MUL_W-1:0]));
        OP_DOT0: acc_r <= $signed(prod[MUL_W-1:0]);
        OP_DOT1: dot_r <= acc_r + $signed(prod[MUL_W-1:0]);
        OP_DD:   dd_r  <= prod[63:0];
        OP_PC:   pc_r  <= prod[63:0];
        OP_C2:   c2_r  <= prod[29:0];
        OP_LO:   rlo_r <= prod[61:0];
        OP_HI:   rhs_r <= {prod[61:0], 32'd0} + {32'd0, rlo_r};
        default: ;
      endcase
    end
  end

  // restoring square root, one root bit (two radicand bits) per cycle
  logic [31:0] sq_t;
  logic [15:0] sq_mag;

  assign sq_t = sq_r + sq_bit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_bit_r <= '0;
    end else if (cmd.sqrt_go) begin
      sq_bit_r <= 32'h4000_0000;
    end else if (sq_bit_r != '0) begin
      sq_bit_r <= sq_bit_r >> 2;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.sqrt_go) begin
      sq_x_r <= cc_r;
      sq_r   <= '0;
    end else if (sq_bit_r != '0) begin
      if (sq_x_r >= sq_t) begin
        sq_x_r <= sq_x_r - sq_t;
        sq_r   <= (sq_r >> 1) + sq_bit_r;
      end else begin
        sq_r   <= sq_r >> 1;
      end
    end
  end

  // round to nearest: remainder above the root bumps it
  assign sq_mag = sq_r[15:0] + 16'(sq_x_r > sq_r);

  // stick decision
  logic signed [MUL_W-1:0] dxs, dys;
  logic [16:0] adx, ady;
  logic [17:0] l1;
  logic [31:0] e2x;
  logic stick_enter, stick_both, turned;

  assign dxs = cx - px;
  assign dys = cy - py;
  assign adx = dxs[MUL_W-1] ? 17'(-dxs) : 17'(dxs);
  assign ady = dys[MUL_W-1] ? 17'(-dys) : 17'(dys);
  assign l1  = {1'b0, adx} + {1'b0, ady};
  assign e2x = {2'd0, e2_r};

  assign stick_enter = (pp_r < e2x) && (cc_r >= e2x);
  assign stick_both  = (pp_r >= e2x) && (cc_r >= e2x);
  // a zero length on either side never counts as a turn
  assign turned = (pp_r != '0) && (cc_r != '0) &&
                  ((dot_r <= 0) || ({dd_r, 30'd0} <= rhs_r));

  // trigger decision
  logic [PULL_BITS-1:0] tc, tp, td;
  logic trg_enter, trg_both;

  assign tc = cmd.trg_sel ? cur_r.right_pull : cur_r.left_pull;
  assign tp = cmd.trg_sel ? prior_rp_r : prior_lp_r;
  assign td = (tc >= tp) ? tc - tp : tp - tc;
  assign trg_enter = (tp < cfg_tenter_r) && (tc >= cfg_tenter_r);
  assign trg_both  = (tp >= cfg_tenter_r) && (tc >= cfg_tenter_r);

  // result assembly
  out_item_t item;

  always_comb begin
    item           = '0;
    item.down_mask = cur_r.buttons;
    item.seq_out   = cur_r.sequence_req;
    item.stamp_out = cur_r.stamp_us;
    case (cmd.src)
      SRC_BTN: begin
        item.kind      = cur_bit ? (touch_hit ? K_TOUCH : K_PRESS) : K_RELEASE;
        item.control   = 5'(idx_r);
        item.magnitude = cur_bit ? PRESS_MAG : 16'd0;
      end
      SRC_STICK: begin
        if (stick_enter) begin
          item.kind = cmd.stick_sel ? K_RSTICK_ENTER : K_LSTICK_ENTER;
        end else begin
          item.kind = cmd.stick_sel ? K_RSTICK_CHANGE : K_LSTICK_CHANGE;
        end
        item.magnitude = sq_mag;
      end
      SRC_TRG: begin
        if (trg_enter) begin
          item.kind = cmd.trg_sel ? K_RTRIG_ENTER : K_LTRIG_ENTER;
        end else begin
          item.kind = cmd.trg_sel ? K_RTRIG_CHANGE : K_LTRIG_CHANGE;
        end
        item.magnitude = {1'b0, tc};
      end
      SRC_FRAME: begin
        item.kind = K_FRAME_END;
        item.last = 1'b1;
      end
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_r <= item;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  assign sts.btn_edge   = cur_bit ^ prior_bit;
  assign sts.btn_last   = (idx_r == IDX_W'(BUTTON_COUNT - 1));
  assign sts.sqrt_busy  = (sq_bit_r != '0);
  assign sts.stick_fire = stick_enter ||
                          (stick_both && ((l1 >= {2'd0, cfg_move_r}) || turned));
  assign sts.trg_fire   = trg_enter || (trg_both && (td >= cfg_tmove_r));
  assign sts.out_free   = !out_valid_r || out_ready;

endmodule
`default_nettype wire

FILE: design/gamepad_activity_classifier_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gamepad_activity_classifier_core: controller report to activity events
// Compares each report with the previous one and emits button, stick,
// trigger and frame-end result items.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one report per item (valid/ready). Taken only while the block is
//           idle; the next report waits until the current frame end is issued.
//   out_* : result items from an output register, one per cycle at most:
//           button edges in ascending bit order, stick events, trigger events,
//           then a frame-end item with last set.
//   cfg_* : register writes, always ready; write only while idle.
// Sequence: a report is accepted, then the buttons are scanned one bit per
//   cycle (an edge waits while the output register is full), the stick
//   threshold is squared, and each stick in turn takes 11 steps of a shared
//   33x33 multiplier, then waits for the 16-step square-root unit started on
//   its third step; the left and right trigger checks and the frame end follow.
// Stall: while the output register holds an unaccepted item, the sequencer
//   holds at the next item to emit; nothing is dropped.
// Reset: registers return to their defaults and the prior report reads as
//   all zero.
// ----------------------------------------------------------------------------
module gamepad_activity_classifier_core import gac_pkg::*; #(
  parameter int BUTTON_COUNT = BUTTON_COUNT_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire in_item_t    in_data,
  output logic             out_valid,
  input  wire logic        out_ready,
  output out_item_t        out_data,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [31:0] cfg_data
);

  cmd_t cmd;
  sts_t sts;

  // sequencer: one report at a time
  gac_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .cmd      (cmd),
    .sts      (sts)
  );

  // datapath: state, arithmetic, output register
  gac_dp #(
    .BUTTON_COUNT (BUTTON_COUNT)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cmd       (cmd),
    .sts       (sts)
  );

`ifndef SYNTHESIS
  // after a report is taken, in_ready is low in the following cycle
  a_one_report: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("report accepted while previous one in flight");

  // last marks exactly the frame-end item
  a_last_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.last == (out_data.kind == K_FRAME_END)))
    else $error("last flag does not match frame-end kind");

  // presses always carry full magnitude
  a_press_mag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.kind == K_PRESS || out_data.kind == K_TOUCH)
      |-> out_data.magnitude == PRESS_MAG)
    else $error("press item with wrong magnitude");
`endif

endmodule
`default_nettype wire
